@@ hw/rtl/rwq_pkg.sv @@
// ----------------------------------------------------------------------------
// rwq_pkg
// Shared types and constants for the resource wait queue: operation and status
// codes, back-end states and the command record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package rwq_pkg;

  typedef enum logic [2:0] {
    KIND_TAKE  = 3'd0,
    KIND_GIVE  = 3'd1,
    KIND_ENQ   = 3'd2,
    KIND_WDRAW = 3'd3,
    KIND_PEEK  = 3'd4,
    KIND_POP   = 3'd5,
    KIND_CLEAR = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_FEW   = 3'd1,
    STS_OVER  = 3'd2,
    STS_BAD   = 3'd3,
    STS_MERGE = 3'd4,
    STS_EMPTY = 3'd5,
    STS_FULL  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    kind_e      kind;
    logic       bad;
    logic [7:0] pid;
    logic [7:0] units;
  } cmd_t;

  localparam logic [7:0] MAX_INV_RST = 8'd1;
  localparam int         CMDQ_DEPTH  = 2;

endpackage

`default_nettype wire

@@ hw/rtl/rwq_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// rwq_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rwq_cmd_fifo
  import rwq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  cmd_t      push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_data_o
);

  localparam int PtrW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CntW = $clog2(CMDQ_DEPTH + 1);

  cmd_t            mem_q [CMDQ_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(CMDQ_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rwq_front.sv @@
// ----------------------------------------------------------------------------
// rwq_front
// Input side: takes request beats and classifies them, flagging requests that
// can be rejected without looking at the wait list.
// ----------------------------------------------------------------------------
`default_nettype none

module rwq_front
  import rwq_pkg::*;
(
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] kind_i,
  input  wire logic [7:0] pid_i,
  input  wire logic [7:0] units_i,
  input  wire logic [7:0] max_i,
  output logic            cmd_valid_o,
  input  wire logic       cmd_ready_i,
  output cmd_t            cmd_o
);

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

  always_comb begin
    cmd_o.kind  = kind_e'(kind_i);
    cmd_o.pid   = pid_i;
    cmd_o.units = units_i;
    case (cmd_o.kind)
      KIND_TAKE, KIND_GIVE, KIND_WDRAW,
      KIND_PEEK, KIND_POP, KIND_CLEAR: cmd_o.bad = 1'b0;
      // pid 0 is reserved; a request larger than the pool can never be met
      KIND_ENQ: cmd_o.bad = (pid_i == 8'd0) || (units_i > max_i);
      default:  cmd_o.bad = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/rwq_back.sv @@
// ----------------------------------------------------------------------------
// rwq_back
// Execution side: owns the free count and the wait-list cell row. Each command
// takes a match step (all cells compared against the pid) then an update step
// that writes the cells, the counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rwq_back
  import rwq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int CntW        = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [7:0]      max_i,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_ready_o,
  input  cmd_t                 cmd_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [2:0]           status_o,
  output logic [7:0]           free_units_o,
  output logic [CntW-1:0]      waiting_count_o,
  output logic                 head_valid_o,
  output logic [7:0]           head_pid_o,
  output logic [7:0]           head_units_o
);

  localparam int IdxW = $clog2(QUEUE_DEPTH);

  bk_state_e             state_q, state_d;
  cmd_t                  op_q;
  logic                  load_op, exec_en, out_free;

  logic [7:0]            pid_q   [QUEUE_DEPTH];
  logic [7:0]            units_q [QUEUE_DEPTH];
  logic [7:0]            pid_d   [QUEUE_DEPTH];
  logic [7:0]            units_d [QUEUE_DEPTH];
  logic [CntW-1:0]       len_q, len_d;
  logic [7:0]            free_q, free_d;

  logic [QUEUE_DEPTH-1:0] hit_c, hit_q;
  logic [IdxW-1:0]        hit_idx_c, hit_idx_q;
  logic [7:0]             hit_units_c, hit_units_q;
  logic                   hit_any_q;

  status_e               status_c;
  logic                  popped;
  logic [8:0]            give_sum, merge_sum;
  logic [7:0]            head_pid_c, head_units_c;

  logic                  out_valid_q;
  logic [2:0]            status_q;
  logic [7:0]            free_out_q, head_pid_q, head_units_q;
  logic [CntW-1:0]       wait_out_q;
  logic                  head_valid_q;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (cmd_valid_i) state_d = BK_LOOK;
      BK_LOOK: state_d = BK_EXEC;
      BK_EXEC: begin
        if (out_free) state_d = cmd_valid_i ? BK_LOOK : BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_ready_o = 1'b0;
    exec_en     = 1'b0;
    case (state_q)
      BK_IDLE: cmd_ready_o = 1'b1;
      BK_LOOK: cmd_ready_o = 1'b0;
      BK_EXEC: begin
        cmd_ready_o = out_free;
        exec_en     = out_free;
      end
      default: cmd_ready_o = 1'b0;
    endcase
  end

  assign load_op = cmd_valid_i & cmd_ready_o;

  // match step: pids are unique in the list, so at most one cell hits
  always_comb begin
    hit_idx_c   = '0;
    hit_units_c = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_c[i] = (CntW'(i) < len_q) && (pid_q[i] == op_q.pid);
      if (hit_c[i]) begin
        hit_idx_c   = hit_idx_c | IdxW'(i);
        hit_units_c = hit_units_c | units_q[i];
      end
    end
  end

  // update step
  always_comb begin
    pid_d     = pid_q;
    units_d   = units_q;
    len_d     = len_q;
    free_d    = free_q;
    status_c  = STS_OK;
    popped    = 1'b0;
    give_sum  = {1'b0, free_q} + {1'b0, op_q.units};
    merge_sum = {1'b0, hit_units_q} + {1'b0, op_q.units};
    case (op_q.kind)
      KIND_TAKE: begin
        if (op_q.units > free_q) status_c = STS_FEW;
        else free_d = free_q - op_q.units;
      end
      KIND_GIVE: begin
        if (give_sum > {1'b0, max_i}) status_c = STS_OVER;
        else free_d = give_sum[7:0];
      end
      KIND_ENQ: begin
        if (op_q.bad) begin
          status_c = STS_BAD;
        end else if (hit_any_q) begin
          if (merge_sum > {1'b0, max_i}) begin
            status_c = STS_MERGE;
          end else begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (hit_q[i]) units_d[i] = merge_sum[7:0];
            end
          end
        end else if (len_q == CntW'(QUEUE_DEPTH)) begin
          status_c = STS_FULL;
        end else begin
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (CntW'(i) == len_q) begin
              pid_d[i]   = op_q.pid;
              units_d[i] = op_q.units;
            end
          end
          len_d = len_q + 1'b1;
        end
      end
      KIND_WDRAW: begin
        // close the gap: every cell from the hit onward takes its successor
        if (hit_any_q) begin
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (IdxW'(i) >= hit_idx_q) begin
              pid_d[i]   = pid_q[i+1];
              units_d[i] = units_q[i+1];
            end
          end
          len_d = len_q - 1'b1;
        end
      end
      KIND_PEEK: begin
        if (len_q == '0) status_c = STS_EMPTY;
      end
      KIND_POP: begin
        if (len_q == '0) begin
          status_c = STS_EMPTY;
        end else begin
          popped = 1'b1;
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            pid_d[i]   = pid_q[i+1];
            units_d[i] = units_q[i+1];
          end
          len_d = len_q - 1'b1;
        end
      end
      KIND_CLEAR: begin
        len_d  = '0;
        free_d = max_i;
      end
      default: status_c = STS_BAD;
    endcase

    if (popped) begin
      head_pid_c   = pid_q[0];
      head_units_c = units_q[0];
    end else if (len_d != '0) begin
      head_pid_c   = pid_d[0];
      head_units_c = units_d[0];
    end else begin
      head_pid_c   = '0;
      head_units_c = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      len_q       <= '0;
      free_q      <= MAX_INV_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_en) begin
        len_q  <= len_d;
        free_q <= free_d;
      end
      if (exec_en) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_op) op_q <= cmd_i;
    if (state_q == BK_LOOK) begin
      hit_q       <= hit_c;
      hit_idx_q   <= hit_idx_c;
      hit_units_q <= hit_units_c;
      hit_any_q   <= |hit_c;
    end
    if (exec_en) begin
      pid_q        <= pid_d;
      units_q      <= units_d;
      status_q     <= status_c;
      free_out_q   <= free_d;
      wait_out_q   <= len_d;
      head_valid_q <= (len_d != '0);
      head_pid_q   <= head_pid_c;
      head_units_q <= head_units_c;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign free_units_o    = free_out_q;
  assign waiting_count_o = wait_out_q;
  assign head_valid_o    = head_valid_q;
  assign head_pid_o      = head_pid_q;
  assign head_units_o    = head_units_q;

endmodule

`default_nettype wire

@@ hw/rtl/resource_wait_queue_unit.sv @@
// A request beat passes the command queue, then the back end's match step
//   (all list cells compared at once) and update step; results are registered.
// A new request enters when idle or on the update step, not while a result waits.
// While a result waits, the front end still fills the 2-entry command queue.
// Reset: wait list empty, free count and pool size 1, no result pending.
// ----------------------------------------------------------------------------
// resource_wait_queue_unit
// Counting resource pool with a FIFO wait list of (pid, units) entries.
// ----------------------------------------------------------------------------
`default_nettype none

module resource_wait_queue_unit
  import rwq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [2:0]                         kind_i,
  input  wire logic [7:0]                         pid_i,
  input  wire logic [7:0]                         units_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [2:0]                              status_o,
  output logic [7:0]                              free_units_o,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0]      waiting_count_o,
  output logic                                    head_valid_o,
  output logic [7:0]                              head_pid_o,
  output logic [7:0]                              head_units_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [7:0]                         cfg_data_i
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0] max_q;
  logic       fr_valid, fr_ready, bk_valid, bk_ready;
  cmd_t       fr_cmd, bk_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_INV_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_q <= cfg_data_i;
    end
  end

  rwq_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .pid_i       (pid_i),
    .units_i     (units_i),
    .max_i       (max_q),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  rwq_cmd_fifo u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_cmd)
  );

  rwq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CntW        (CntW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .max_i           (max_q),
    .cmd_valid_i     (bk_valid),
    .cmd_ready_o     (bk_ready),
    .cmd_i           (bk_cmd),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .free_units_o    (free_units_o),
    .waiting_count_o (waiting_count_o),
    .head_valid_o    (head_valid_o),
    .head_pid_o      (head_pid_o),
    .head_units_o    (head_units_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/rwq_checker.sv @@
// ----------------------------------------------------------------------------
// rwq_checker
// Port-level checks for the resource wait queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rwq_checker
  import rwq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic [2:0]                         status_o,
  input wire logic [7:0]                         free_units_o,
  input wire logic [$clog2(QUEUE_DEPTH + 1)-1:0] waiting_count_o,
  input wire logic                               head_valid_o,
  input wire logic [7:0]                         head_pid_o,
  input wire logic [7:0]                         head_units_o
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(free_units_o) && $stable(waiting_count_o)
      && $stable(head_pid_o) && $stable(head_units_o))
    else $error("result beat changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> waiting_count_o <= CntW'(QUEUE_DEPTH))
    else $error("waiting count beyond list depth");

  a_head_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> head_valid_o == (waiting_count_o != '0))
    else $error("head flag disagrees with waiting count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STS_FULL |-> waiting_count_o == CntW'(QUEUE_DEPTH))
    else $error("list-full status with room left");

  a_head_pid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && head_valid_o |-> head_pid_o != 8'd0)
    else $error("reserved pid at list head");

endmodule

bind resource_wait_queue_unit rwq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rwq_checker (.*);

`default_nettype wire

@@ dv/tb_resource_wait_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resource_wait_queue_unit
// Self-checking bench for the resource pool and wait list. A queue-fed driver
// sends operation beats, a monitor predicts every result from its own copy of
// the pool and list and compares it field by field. Pool size is rewritten
// between phases while the unit is idle; idling and stalls vary per phase.
// ----------------------------------------------------------------------------

module tb_resource_wait_queue_unit;
  import rwq_pkg::*;

  localparam int         LIST_DEPTH     = 16;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         MAX_PRINTED    = 40;
  localparam logic [2:0] KIND_UNUSED    = 3'd7;

  localparam int STYLE_FILL  = 0;
  localparam int STYLE_MIXED = 1;
  localparam int STYLE_DRAIN = 2;
  localparam int STYLE_NOISE = 3;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] pid;
    logic [7:0] units;
  } op_item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] free_units;
    logic [4:0] waiting;
    logic       head_valid;
    logic [7:0] head_pid;
    logic [7:0] head_units;
  } pool_reply_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       op_valid  = 1'b0;
  logic [2:0] op_kind   = '0;
  logic [7:0] op_pid    = '0;
  logic [7:0] op_units  = '0;
  logic       res_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data  = '0;
  logic       op_fire   = 1'b0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [2:0] status_o;
  logic [7:0] free_units_o;
  logic [4:0] waiting_count_o;
  logic       head_valid_o;
  logic [7:0] head_pid_o;
  logic [7:0] head_units_o;
  logic       cfg_ready_o;

  resource_wait_queue_unit #(
    .QUEUE_DEPTH(LIST_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (op_valid),
    .in_ready_o     (in_ready_o),
    .kind_i         (op_kind),
    .pid_i          (op_pid),
    .units_i        (op_units),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (res_ready),
    .status_o       (status_o),
    .free_units_o   (free_units_o),
    .waiting_count_o(waiting_count_o),
    .head_valid_o   (head_valid_o),
    .head_pid_o     (head_pid_o),
    .head_units_o   (head_units_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // stimulus and expected replies
  op_item_t    pending_ops[$];
  pool_reply_t replies_due[$];
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic [7:0]  recent_pid[8];

  // predictor state: pool size, free count and the wait list
  logic [7:0]  pool_size = MAX_INV_RST;
  logic [7:0]  pool_free = MAX_INV_RST;
  logic [7:0]  wait_pid[LIST_DEPTH];
  logic [7:0]  wait_units[LIST_DEPTH];
  int          wait_len  = 0;

  int          n_errors  = 0;
  int          n_ops     = 0;
  int          n_replies = 0;
  int          quiet_cycles = 0;
  int          status_seen[8];

  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_PRINTED) $display("[%0t] MISMATCH %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(input string fld, input logic [7:0] got_v,
                             input logic [7:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("reply %0d: %s got %0h, want %0h",
                                n_replies, fld, got_v, want_v));
  endtask

  task automatic apply_pool_op(input op_item_t op, output pool_reply_t r);
    int         at;
    int         w;
    logic [8:0] sum;
    logic       popped;
    logic [7:0] pop_pid;
    logic [7:0] pop_units;
    r.status  = STS_OK;
    popped    = 1'b0;
    pop_pid   = '0;
    pop_units = '0;
    at        = -1;
    case (op.kind)
      KIND_TAKE: begin
        if (op.units > pool_free) r.status = STS_FEW;
        else pool_free = pool_free - op.units;
      end
      KIND_GIVE: begin
        sum = {1'b0, pool_free} + {1'b0, op.units};
        if (sum > {1'b0, pool_size}) r.status = STS_OVER;
        else pool_free = sum[7:0];
      end
      KIND_ENQ: begin
        if (op.pid == 8'd0 || op.units > pool_size) begin
          r.status = STS_BAD;
        end else begin
          for (int i = 0; i < wait_len; i++)
            if (at < 0 && wait_pid[i] == op.pid) at = i;
          if (at >= 0) begin
            // same pid already waiting: grow its request in place
            sum = {1'b0, wait_units[at]} + {1'b0, op.units};
            if (sum > {1'b0, pool_size}) r.status = STS_MERGE;
            else wait_units[at] = sum[7:0];
          end else if (wait_len >= LIST_DEPTH) begin
            r.status = STS_FULL;
          end else begin
            wait_pid[wait_len]   = op.pid;
            wait_units[wait_len] = op.units;
            wait_len++;
          end
        end
      end
      KIND_WDRAW: begin
        w = 0;
        for (int i = 0; i < wait_len; i++) begin
          if (wait_pid[i] != op.pid) begin
            wait_pid[w]   = wait_pid[i];
            wait_units[w] = wait_units[i];
            w++;
          end
        end
        wait_len = w;
      end
      KIND_PEEK: begin
        if (wait_len == 0) r.status = STS_EMPTY;
      end
      KIND_POP: begin
        if (wait_len == 0) begin
          r.status = STS_EMPTY;
        end else begin
          popped    = 1'b1;
          pop_pid   = wait_pid[0];
          pop_units = wait_units[0];
          for (int i = 1; i < wait_len; i++) begin
            wait_pid[i-1]   = wait_pid[i];
            wait_units[i-1] = wait_units[i];
          end
          wait_len--;
        end
      end
      KIND_CLEAR: begin
        wait_len  = 0;
        pool_free = pool_size;
      end
      default: r.status = STS_BAD;
    endcase
    r.free_units = pool_free;
    r.waiting    = 5'(wait_len);
    r.head_valid = (wait_len > 0);
    if (popped) begin
      r.head_pid   = pop_pid;
      r.head_units = pop_units;
    end else if (wait_len > 0) begin
      r.head_pid   = wait_pid[0];
      r.head_units = wait_units[0];
    end else begin
      r.head_pid   = '0;
      r.head_units = '0;
    end
    status_seen[r.status]++;
  endtask

  // driver: next beat only once the current one has gone through
  always @(negedge clk_i) begin
    op_item_t nxt;
    logic     go;
    if (rst_ni && (!op_valid || op_fire)) begin
      go = (pending_ops.size() > 0) && ($urandom_range(0, 99) >= send_idle_pct);
      if (go) begin
        nxt = pending_ops[0];
        pending_ops.delete(0);
        op_kind  <= nxt.kind;
        op_pid   <= nxt.pid;
        op_units <= nxt.units;
      end
      op_valid <= go;
    end
    res_ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: check replies, track pool size, predict on every accepted beat
  always @(posedge clk_i) begin
    pool_reply_t want;
    op_item_t    op;
    pool_reply_t pred;
    op_fire <= op_valid && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && res_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("reply %0d arrived with nothing expected", n_replies));
        end else begin
          want = replies_due[0];
          replies_due.delete(0);
          check_field("status",        status_o,        want.status);
          check_field("free_units",    free_units_o,    want.free_units);
          check_field("waiting_count", waiting_count_o, want.waiting);
          check_field("head_valid",    head_valid_o,    want.head_valid);
          check_field("head_pid",      head_pid_o,      want.head_pid);
          check_field("head_units",    head_units_o,    want.head_units);
        end
        n_replies++;
      end
      if (cfg_valid && cfg_ready_o) pool_size = cfg_data;
      if (op_valid && in_ready_o) begin
        op.kind  = op_kind;
        op.pid   = op_pid;
        op.units = op_units;
        apply_pool_op(op, pred);
        replies_due.insert(replies_due.size(), pred);
        n_ops++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (op_valid && in_ready_o) || (out_valid_o && res_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d replies outstanding",
               quiet_cycles, replies_due.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_op(input logic [2:0] kind, input logic [7:0] pid,
                        input logic [7:0] units);
    op_item_t op;
    op.kind  = kind;
    op.pid   = pid;
    op.units = units;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  function automatic logic [7:0] pick_units(input logic [7:0] pool);
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'($urandom_range(0, pool));
      2:       return 8'($urandom_range(0, 3));
      default: return 8'(pool + $urandom_range(0, 2) - 1); // straddle the pool size
    endcase
  endfunction

  function automatic logic [7:0] pick_pid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return recent_pid[$urandom_range(0, 7)];
    if (r < 70) return 8'd0;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic op_item_t make_op(input int style, input logic [7:0] pool);
    op_item_t op;
    int       r;
    r        = $urandom_range(0, 99);
    op.kind  = KIND_PEEK;
    op.pid   = pick_pid();
    op.units = pick_units(pool);
    case (style)
      STYLE_FILL: begin
        op.kind  = KIND_ENQ;
        op.pid   = (r < 85) ? 8'($urandom_range(1, 255)) : pick_pid();
        op.units = 8'($urandom_range(0, pool >> 2));
      end
      STYLE_DRAIN: begin
        op.kind = (r < 60) ? KIND_POP : ((r < 85) ? KIND_WDRAW : KIND_PEEK);
      end
      STYLE_NOISE: begin
        op.kind  = 3'($urandom_range(0, 7));
        op.pid   = 8'($urandom);
        op.units = 8'($urandom);
      end
      default: begin
        if (r < 14)      op.kind = KIND_TAKE;
        else if (r < 28) op.kind = KIND_GIVE;
        else if (r < 58) op.kind = KIND_ENQ;
        else if (r < 70) op.kind = KIND_WDRAW;
        else if (r < 78) op.kind = KIND_PEEK;
        else if (r < 92) op.kind = KIND_POP;
        else if (r < 97) op.kind = KIND_CLEAR;
        else             op.kind = KIND_UNUSED;
      end
    endcase
    if (op.kind == KIND_ENQ && op.pid != 8'd0) recent_pid[$urandom_range(0, 7)] = op.pid;
    return op;
  endfunction

  task automatic add_random_ops(input logic [7:0] pool, input int count);
    int       r;
    int       style;
    int       burst;
    op_item_t op;
    while (count > 0) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        style = STYLE_FILL;
        burst = $urandom_range(14, 20);
      end else if (r < 8) begin
        style = STYLE_MIXED;
        burst = $urandom_range(8, 30);
      end else if (r == 8) begin
        style = STYLE_DRAIN;
        burst = $urandom_range(4, 12);
      end else begin
        style = STYLE_NOISE;
        burst = $urandom_range(2, 6);
      end
      repeat (burst) begin
        op = make_op(style, pool);
        pending_ops.insert(pending_ops.size(), op);
      end
      count -= burst;
    end
  endtask

  task automatic wait_idle();
    while (pending_ops.size() > 0 || op_valid || replies_due.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_pool_size(input logic [7:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] pool, input int send_pct,
                           input int recv_pct, input int count);
    write_pool_size(pool);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_random_ops(pool, count);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      recent_pid[i]  = 8'(i + 1);
      status_seen[i] = 0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: pool of 255, free count still at its reset value of 1
    write_pool_size(8'd255);
    add_op(KIND_PEEK,   8'd0,   8'd0);    // empty list
    add_op(KIND_POP,    8'd0,   8'd0);    // empty list
    add_op(KIND_TAKE,   8'd0,   8'd255);  // too few free
    add_op(KIND_GIVE,   8'd0,   8'd254);
    add_op(KIND_GIVE,   8'd0,   8'd1);    // would pass the pool size
    add_op(KIND_TAKE,   8'd0,   8'd255);
    add_op(KIND_CLEAR,  8'd0,   8'd0);
    add_op(KIND_ENQ,    8'd0,   8'd7);    // pid zero rejected
    add_op(KIND_ENQ,    8'd255, 8'd0);
    add_op(KIND_ENQ,    8'd255, 8'd255);  // merge up to the limit
    add_op(KIND_ENQ,    8'd255, 8'd1);    // merge overflow
    add_op(KIND_ENQ,    8'd1,   8'd128);
    add_op(KIND_ENQ,    8'd128, 8'd1);
    add_op(KIND_ENQ,    8'd1,   8'd2);    // merge into a non-head entry
    add_op(KIND_PEEK,   8'd0,   8'd0);
    add_op(KIND_WDRAW,  8'd128, 8'd0);    // last entry, list shortens
    add_op(KIND_WDRAW,  8'd0,   8'd0);    // absent pid is not an error
    add_op(KIND_WDRAW,  8'd77,  8'd0);
    add_op(KIND_POP,    8'd0,   8'd0);
    add_op(KIND_UNUSED, 8'd255, 8'd255);  // unused opcode
    add_op(KIND_ENQ,    8'd128, 8'd0);
    add_op(KIND_WDRAW,  8'd1,   8'd0);    // removes the head
    add_op(KIND_POP,    8'd0,   8'd0);
    add_op(KIND_CLEAR,  8'd0,   8'd0);

    run_phase(8'd128,  0,  0, 380);
    run_phase(8'd0,   80,  0, 150);       // give fails while free count exceeds pool
    run_phase(8'd7,    0, 80, 350);
    run_phase(8'd100, 19, 19, 420);
    run_phase(8'd1,    0,  0, 150);
    run_phase(8'd200, 19, 19, 350);
    wait_idle();

    $display("%0d operations and %0d replies checked, pool sizes 0 to 255 in 7 settings",
             n_ops, n_replies);
    $display("status mix: ok %0d few %0d over %0d bad %0d merge %0d empty %0d full %0d",
             status_seen[STS_OK], status_seen[STS_FEW], status_seen[STS_OVER],
             status_seen[STS_BAD], status_seen[STS_MERGE], status_seen[STS_EMPTY],
             status_seen[STS_FULL]);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
